// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is applied.
`define SNSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds through reset.
`define SNSE_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/snse_pkg.sv =====
// Shared types, constants and step functions of the steering error core.
package snse_pkg;

    localparam int CHANNELS   = 4;
    localparam int RAW_W      = 8;
    localparam int NORM_W     = 7;
    localparam int NORM_FULL  = 100;
    localparam int NNUM_W     = 15;
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int SREM_W     = 19;
    localparam int DNUM_W     = 28;
    localparam int DEN_W      = 17;
    localparam int QUO_W      = 17;
    localparam int CMP_W      = DNUM_W + 6;
    localparam int STEER_W    = 18;
    localparam int UNIT_W     = 14;
    localparam int Q_SHIFT    = 12;
    localparam int M0_GAIN    = 5;
    localparam int M1_GAIN    = 20 * 4096;
    localparam int ROOT_BIAS  = 256;
    localparam int CFG_IDX_W  = 3;
    localparam int ADDR_W     = 5;
    localparam logic [RAW_W-1:0] MIN_RESET = 8'd1;
    localparam logic [RAW_W-1:0] MAX_RESET = 8'd200;

    typedef enum logic {
        MODE_MAGNITUDE = 1'b0,
        MODE_DIFF      = 1'b1
    } mode_t;

    typedef logic [CHANNELS-1:0][RAW_W-1:0]  raw_vec_t;
    typedef logic [CHANNELS-1:0][NORM_W-1:0] norm_vec_t;

    typedef struct packed {
        norm_vec_t norm;
        mode_t     mode;
        logic      fault;
    } side_t;

    // Normalizer lane: restoring division of (raw-min)*100 by (max-min).
    typedef struct packed {
        logic [NNUM_W-1:0] rem;
        logic [NORM_W-1:0] quo;
        logic [RAW_W-1:0]  den;
        logic              force_en;
        logic [NORM_W-1:0] force_val;
    } nlane_t;

    typedef struct packed {
        nlane_t [CHANNELS-1:0] lane;
        mode_t                 mode;
        logic                  fault;
    } nstage_t;

    // Square root lane: two radicand bits per step.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } slane_t;

    typedef struct packed {
        slane_t lft;
        slane_t rgt;
        side_t  side;
    } sstage_t;

    // Divider: magnitude quotient, sign applied at the end.
    typedef struct packed {
        logic [DNUM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [DEN_W-1:0]  den;
        logic              neg;
        side_t             side;
    } dstage_t;

    function automatic nstage_t norm_step(nstage_t s, int bitpos);
        nstage_t           r;
        logic [NNUM_W-1:0] sub;
        r = s;
        for (int c = 0; c < CHANNELS; c++) begin
            sub = NNUM_W'(s.lane[c].den) << bitpos;
            if (s.lane[c].rem >= sub) begin
                r.lane[c].rem         = s.lane[c].rem - sub;
                r.lane[c].quo[bitpos] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic slane_t sqrt_step(slane_t s);
        slane_t            r;
        logic [SREM_W-1:0] cur;
        logic [SREM_W-1:0] trial;
        cur   = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
        trial = SREM_W'({s.root, 2'b01});
        r.rad = s.rad << 2;
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dstage_t div_step(dstage_t s, int bitpos);
        dstage_t          r;
        logic [CMP_W-1:0] sub;
        r   = s;
        sub = CMP_W'(s.den) << bitpos;
        if (CMP_W'(s.rem) >= sub) begin
            r.rem         = DNUM_W'(CMP_W'(s.rem) - sub);
            r.quo[bitpos] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/snse_norm.sv =====
// Four-lane pipelined normalizer against the calibration window.
module snse_norm import snse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  raw_vec_t in_raw,
    input  mode_t    in_mode,
    input  raw_vec_t cfg_min,
    input  raw_vec_t cfg_max,
    output logic     out_valid,
    input  logic     out_ready,
    output side_t    out_side
);
    localparam int NST = NORM_W + 1;

    logic    v_reg  [NST];
    nstage_t st_reg [NST];
    logic [NST:0] en;
    nstage_t st0_next;

    assign en[NST]  = out_ready;
    assign in_ready = en[0];

    always_comb begin
        logic [RAW_W:0] d;
        logic [RAW_W-1:0] w;
        st0_next       = '0;
        st0_next.mode  = in_mode;
        for (int c = 0; c < CHANNELS; c++) begin
            d = {1'b0, in_raw[c]} - {1'b0, cfg_min[c]};
            w = cfg_max[c] - cfg_min[c];
            st0_next.lane[c].den = w;
            st0_next.lane[c].rem = NNUM_W'(d[RAW_W-1:0]) * NNUM_W'(NORM_FULL);
            if (cfg_max[c] <= cfg_min[c]) begin
                st0_next.fault              = 1'b1;
                st0_next.lane[c].force_en   = 1'b1;
            end else if (d[RAW_W] || d == '0) begin
                st0_next.lane[c].force_en   = 1'b1;
            end else if (d[RAW_W-1:0] >= w) begin
                st0_next.lane[c].force_en   = 1'b1;
                st0_next.lane[c].force_val  = NORM_W'(NORM_FULL);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en[0]) begin
            v_reg[0] <= in_valid;
        end
        if (en[0]) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k < NST; k++) begin : g_st
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (en[k]) begin
                st_reg[k] <= norm_step(st_reg[k-1], NORM_W - k);
            end
        end
    end

    assign out_valid = v_reg[NST-1];

    always_comb begin
        out_side.mode  = st_reg[NST-1].mode;
        out_side.fault = st_reg[NST-1].fault;
        for (int c = 0; c < CHANNELS; c++) begin
            out_side.norm[c] = st_reg[NST-1].lane[c].force_en ?
                               st_reg[NST-1].lane[c].force_val : st_reg[NST-1].lane[c].quo;
        end
    end
endmodule

// ===== rtl/core/snse_sqrt.sv =====
// Pipelined square roots of the left and right vector magnitudes.
module snse_sqrt import snse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  side_t             in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_lroot,
    output logic [ROOT_W-1:0] out_rroot
);
    localparam int NST = ROOT_W + 1;

    logic    v_reg  [NST];
    sstage_t st_reg [NST];
    logic [NST:0] en;
    sstage_t st0_next;

    assign en[NST]  = out_ready;
    assign in_ready = en[0];

    // Square and sum; the Q8 scaling shifts the sum up by sixteen.
    always_comb begin
        logic [NNUM_W:0] ls;
        logic [NNUM_W:0] rs;
        ls = (NNUM_W+1)'(in_side.norm[0]) * (NNUM_W+1)'(in_side.norm[0])
           + (NNUM_W+1)'(in_side.norm[1]) * (NNUM_W+1)'(in_side.norm[1]);
        rs = (NNUM_W+1)'(in_side.norm[3]) * (NNUM_W+1)'(in_side.norm[3])
           + (NNUM_W+1)'(in_side.norm[2]) * (NNUM_W+1)'(in_side.norm[2]);
        st0_next          = '0;
        st0_next.side     = in_side;
        st0_next.lft.rad  = {ls, 16'd0};
        st0_next.rgt.rad  = {rs, 16'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en[0]) begin
            v_reg[0] <= in_valid;
        end
        if (en[0]) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    for (genvar k = 1; k < NST; k++) begin : g_st
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (en[k]) begin
                st_reg[k].lft  <= sqrt_step(st_reg[k-1].lft);
                st_reg[k].rgt  <= sqrt_step(st_reg[k-1].rgt);
                st_reg[k].side <= st_reg[k-1].side;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_side  = st_reg[NST-1].side;
    assign out_lroot = st_reg[NST-1].lft.root;
    assign out_rroot = st_reg[NST-1].rgt.root;
endmodule

// ===== rtl/core/snse_div.sv =====
// Pipelined signed ratio divider with the output register.
module snse_div import snse_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  side_t                     in_side,
    input  logic [ROOT_W-1:0]         in_lroot,
    input  logic [ROOT_W-1:0]         in_rroot,
    output logic                      out_valid,
    input  logic                      out_ready,
    output side_t                     out_side,
    output logic signed [STEER_W-1:0] out_steer,
    output logic signed [UNIT_W-1:0]  out_unit
);
    localparam int NST = QUO_W + 1;

    logic    v_reg  [NST];
    dstage_t st_reg [NST];
    logic [NST:0] en;
    dstage_t st0_next;
    logic                      ov_reg;
    side_t                     oside_reg;
    logic signed [STEER_W-1:0] steer_reg, steer_next;
    logic signed [UNIT_W-1:0]  unit_reg, unit_next;

    assign en[NST]  = !ov_reg || out_ready;
    assign in_ready = en[0];

    always_comb begin
        logic [ROOT_W:0]  ri;
        logic [ROOT_W:0]  diff;
        logic [ROOT_W:0]  mag;
        logic [RAW_W:0]   d1;
        logic [NORM_W-1:0] m1;
        st0_next      = '0;
        st0_next.side = in_side;
        ri   = {1'b0, in_rroot[ROOT_W-1:8], 8'd0};
        diff = ri - {1'b0, in_lroot};
        mag  = diff[ROOT_W] ? -diff : diff;
        d1   = {2'b0, in_side.norm[3]} - {2'b0, in_side.norm[0]};
        m1   = d1[RAW_W] ? NORM_W'(-d1) : NORM_W'(d1);
        if (in_side.mode == MODE_MAGNITUDE) begin
            st0_next.neg = diff[ROOT_W];
            st0_next.rem = DNUM_W'(mag) << Q_SHIFT;
            st0_next.den = DEN_W'(in_lroot) + DEN_W'(in_rroot) + DEN_W'(ROOT_BIAS);
        end else begin
            st0_next.neg = d1[RAW_W];
            st0_next.rem = DNUM_W'(m1) * DNUM_W'(M1_GAIN);
            st0_next.den = DEN_W'(in_side.norm[3]) + DEN_W'(in_side.norm[0]) + DEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en[0]) begin
            v_reg[0] <= in_valid;
        end
        if (en[0]) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    for (genvar k = 1; k < NST; k++) begin : g_st
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (en[k]) begin
                st_reg[k] <= div_step(st_reg[k-1], QUO_W - k);
            end
        end
    end

    // Apply the sign, then scale the unit ratio in magnitude mode.
    always_comb begin
        logic [STEER_W-1:0] q;
        q = {1'b0, st_reg[NST-1].quo};
        if (st_reg[NST-1].neg) begin
            q = -q;
        end
        if (st_reg[NST-1].side.mode == MODE_MAGNITUDE) begin
            unit_next  = UNIT_W'(q);
            steer_next = STEER_W'((q << 2) + q);
        end else begin
            unit_next  = '0;
            steer_next = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en[NST]) begin
            ov_reg <= v_reg[NST-1];
        end
        if (en[NST]) begin
            oside_reg <= st_reg[NST-1].side;
            steer_reg <= steer_next;
            unit_reg  <= unit_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_side  = oside_reg;
    assign out_steer = steer_reg;
    assign out_unit  = unit_reg;
endmodule

// ===== rtl/core/sensor_normalize_steer_error_core.sv =====
// Top level: calibration registers and the normalize, root and divide pipeline.
//
//  channel   direction  handshake          carries
//  s_*       in         s_valid/s_ready    four raw readings and the mode
//  m_*       out        m_valid/m_ready    four percentages, steer error, ratio, fault
//  apb       in/out     psel/penable       eight calibration bytes, min then max
//
// One request enters every cycle while the output is not stalled; a request
// passes the normalizer (one quotient bit a stage), the square root (one root bit
// a stage) and the divider (one quotient bit a stage), then the output register.
// Synchronous active-low reset clears every valid bit and loads min 1, max 200.
// A stall holds each full stage; empty stages still fill, so bubbles collapse.
module sensor_normalize_steer_error_core import snse_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RAW_W-1:0]          s_raw_left,
    input  logic [RAW_W-1:0]          s_raw_left_diag,
    input  logic [RAW_W-1:0]          s_raw_right_diag,
    input  logic [RAW_W-1:0]          s_raw_right,
    input  logic                      s_mode,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [NORM_W-1:0]         m_norm_left,
    output logic [NORM_W-1:0]         m_norm_left_diag,
    output logic [NORM_W-1:0]         m_norm_right_diag,
    output logic [NORM_W-1:0]         m_norm_right,
    output logic signed [STEER_W-1:0] m_steer_error,
    output logic signed [UNIT_W-1:0]  m_unit_ratio,
    output logic                      m_calib_fault
);
    raw_vec_t min_reg;
    raw_vec_t max_reg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    raw_vec_t  raw_vec;
    logic      n_valid, n_ready, q_valid, q_ready;
    side_t     n_side, q_side, o_side;
    logic [ROOT_W-1:0] q_lroot, q_rroot;

    // Calibration registers: zero-wait APB, word per register.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                min_reg[c] <= MIN_RESET;
                max_reg[c] <= MAX_RESET;
            end
        end else if (cfg_wr) begin
            if (32'(cfg_idx) < CHANNELS) begin
                min_reg[cfg_idx[1:0]] <= pwdata[RAW_W-1:0];
            end else begin
                max_reg[cfg_idx[1:0]] <= pwdata[RAW_W-1:0];
            end
        end
    end

    always_comb begin
        if (32'(cfg_idx) < CHANNELS) begin
            prdata = {24'd0, min_reg[cfg_idx[1:0]]};
        end else begin
            prdata = {24'd0, max_reg[cfg_idx[1:0]]};
        end
    end

    assign raw_vec = {s_raw_right, s_raw_right_diag, s_raw_left_diag, s_raw_left};

    // Normalize each channel to a clamped percentage.
    snse_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_raw    (raw_vec),
        .in_mode   (mode_t'(s_mode)),
        .cfg_min   (min_reg),
        .cfg_max   (max_reg),
        .out_valid (n_valid),
        .out_ready (n_ready),
        .out_side  (n_side)
    );

    // Left and right magnitudes in Q8.
    snse_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (n_valid),
        .in_ready  (n_ready),
        .in_side   (n_side),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_side  (q_side),
        .out_lroot (q_lroot),
        .out_rroot (q_rroot)
    );

    // Difference over sum in Q12, then the mode gain.
    snse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_side   (q_side),
        .in_lroot  (q_lroot),
        .in_rroot  (q_rroot),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_side  (o_side),
        .out_steer (m_steer_error),
        .out_unit  (m_unit_ratio)
    );

    assign m_norm_left       = o_side.norm[0];
    assign m_norm_left_diag  = o_side.norm[1];
    assign m_norm_right_diag = o_side.norm[2];
    assign m_norm_right      = o_side.norm[3];
    assign m_calib_fault     = o_side.fault;
endmodule

// ===== rtl/core/snse_checker.sv =====
// Port-level checks of the steering error core, bound to the top level.
`include "assert_macros.svh"

module snse_checker import snse_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [STEER_W-1:0] m_steer_error,
    input logic signed [UNIT_W-1:0]  m_unit_ratio
);
    logic signed [STEER_W-1:0] unit_x5;

    assign unit_x5 = STEER_W'(STEER_W'(m_unit_ratio) * STEER_W'(M0_GAIN));

    `SNSE_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `SNSE_ASSERT(a_hold_steer, aclk, aresetn, m_valid && !m_ready |=> $stable(m_steer_error), "steer moved")
    `SNSE_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid, "result after reset")
    `SNSE_ASSERT(a_gain, aclk, aresetn, m_valid && m_unit_ratio != 0 |-> m_steer_error == unit_x5, "gain")
endmodule

bind sensor_normalize_steer_error_core snse_checker u_snse_checker (.*);

// ===== tb/sv/sensor_normalize_steer_error_core_tb.sv =====
// Testbench for the steering error core: normalization, both error modes and calibration.
module sensor_normalize_steer_error_core_tb;
    import snse_pkg::*;

    // Register byte addresses, minima first, then maxima.
    localparam logic [ADDR_W-1:0] REG_MIN_LEFT       = 5'd0;
    localparam logic [ADDR_W-1:0] REG_MIN_LEFT_DIAG  = 5'd4;
    localparam logic [ADDR_W-1:0] REG_MIN_RIGHT_DIAG = 5'd8;
    localparam logic [ADDR_W-1:0] REG_MIN_RIGHT      = 5'd12;
    localparam logic [ADDR_W-1:0] REG_MAX_LEFT       = 5'd16;
    localparam logic [ADDR_W-1:0] REG_MAX_LEFT_DIAG  = 5'd20;
    localparam logic [ADDR_W-1:0] REG_MAX_RIGHT_DIAG = 5'd24;
    localparam logic [ADDR_W-1:0] REG_MAX_RIGHT      = 5'd28;
    localparam int LATENCY     = 45;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [NORM_W-1:0]         nl, nld, nrd, nr;
        logic signed [STEER_W-1:0] steer;
        logic signed [UNIT_W-1:0]  unit;
        logic                      fault;
    } steer_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [RAW_W-1:0] s_raw_left = '0, s_raw_left_diag = '0;
    logic [RAW_W-1:0] s_raw_right_diag = '0, s_raw_right = '0;
    logic s_mode = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [NORM_W-1:0] m_norm_left, m_norm_left_diag, m_norm_right_diag, m_norm_right;
    logic signed [STEER_W-1:0] m_steer_error;
    logic signed [UNIT_W-1:0] m_unit_ratio;
    logic m_calib_fault;

    // Calibration copy kept in step with every register write.
    logic [RAW_W-1:0] cal_min [CHANNELS];
    logic [RAW_W-1:0] cal_max [CHANNELS];

    steer_result_t expected_results[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;

    sensor_normalize_steer_error_core dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Bound the run; a hang is a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // Truncating division toward zero for a dividend of either sign and a positive divisor.
    function automatic longint div_trunc(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / b;
        return (a < 0) ? -q : q;
    endfunction

    function automatic steer_result_t predict_steer(raw_vec_t raw, mode_t mode);
        steer_result_t r;
        longint n[CHANNELS];
        longint q, lm, rm, ri, unit, steer;
        bit flt;
        flt = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (cal_max[c] <= cal_min[c]) begin
                flt = 1'b1;
                n[c] = 0;
            end else begin
                q = div_trunc((longint'(raw[c]) - cal_min[c]) * 100,
                              longint'(cal_max[c]) - cal_min[c]);
                n[c] = q < 0 ? 0 : (q > 100 ? 100 : q);
            end
        end
        if (mode == MODE_MAGNITUDE) begin
            lm = int_sqrt((n[0] * n[0] + n[1] * n[1]) * 65536);
            rm = int_sqrt((n[3] * n[3] + n[2] * n[2]) * 65536);
            ri = (rm >> 8) << 8;
            unit = div_trunc((ri - lm) * 4096, lm + rm + 256);
            steer = unit * 5;
        end else begin
            unit = 0;
            steer = div_trunc((n[3] - n[0]) * 20 * 4096, n[3] + n[0] + 1);
        end
        r.nl = n[0]; r.nld = n[1]; r.nrd = n[2]; r.nr = n[3];
        r.steer = steer; r.unit = unit; r.fault = flt;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Receiver: stall at random, or hold off entirely during the pressure test.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        steer_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = expected_results.pop_front();
                if (m_norm_left != w.nl) report_mismatch("norm_left", m_norm_left, w.nl);
                if (m_norm_left_diag != w.nld)
                    report_mismatch("norm_left_diag", m_norm_left_diag, w.nld);
                if (m_norm_right_diag != w.nrd)
                    report_mismatch("norm_right_diag", m_norm_right_diag, w.nrd);
                if (m_norm_right != w.nr) report_mismatch("norm_right", m_norm_right, w.nr);
                if (m_steer_error != w.steer)
                    report_mismatch("steer_error", m_steer_error, w.steer);
                if (m_unit_ratio != w.unit) report_mismatch("unit_ratio", m_unit_ratio, w.unit);
                if (m_calib_fault != w.fault)
                    report_mismatch("calib_fault", m_calib_fault, w.fault);
            end
        end
    end

    // Offer one request after a random gap and hold it until accepted.
    // Valid stays high into the next request when there is no gap.
    task automatic send_request(logic [7:0] l, logic [7:0] ld, logic [7:0] rd,
                                logic [7:0] r, mode_t mode);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_left <= l; s_raw_left_diag <= ld;
        s_raw_right_diag <= rd; s_raw_right <= r;
        s_mode <= mode;
        expected_results.push_back(predict_steer({r, rd, ld, l}, mode));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [7:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cal_min[0] = (addr == REG_MIN_LEFT) ? value : cal_min[0];
        case (addr)
            REG_MIN_LEFT_DIAG:  cal_min[1] = value;
            REG_MIN_RIGHT_DIAG: cal_min[2] = value;
            REG_MIN_RIGHT:      cal_min[3] = value;
            REG_MAX_LEFT:       cal_max[0] = value;
            REG_MAX_LEFT_DIAG:  cal_max[1] = value;
            REG_MAX_RIGHT_DIAG: cal_max[2] = value;
            REG_MAX_RIGHT:      cal_max[3] = value;
            default: ;
        endcase
    endtask

    task automatic set_window(logic [7:0] lo [CHANNELS], logic [7:0] hi [CHANNELS]);
        write_reg(REG_MIN_LEFT, lo[0]);       write_reg(REG_MIN_LEFT_DIAG, lo[1]);
        write_reg(REG_MIN_RIGHT_DIAG, lo[2]); write_reg(REG_MIN_RIGHT, lo[3]);
        write_reg(REG_MAX_LEFT, hi[0]);       write_reg(REG_MAX_LEFT_DIAG, hi[1]);
        write_reg(REG_MAX_RIGHT_DIAG, hi[2]); write_reg(REG_MAX_RIGHT, hi[3]);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle.
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_raw;
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_request(rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                         mode_t'($urandom_range(1)));
    endtask

    // Extremes of every field in both modes at the reset calibration.
    task automatic test_directed_extremes;
        for (int m = 0; m < 2; m++) begin
            send_request(8'd0, 8'd0, 8'd0, 8'd0, mode_t'(m));
            send_request(8'd255, 8'd255, 8'd255, 8'd255, mode_t'(m));
            send_request(8'd1, 8'd1, 8'd200, 8'd200, mode_t'(m));
            send_request(8'd200, 8'd200, 8'd1, 8'd1, mode_t'(m));
            send_request(8'd255, 8'd0, 8'd0, 8'd255, mode_t'(m));
            send_request(8'd100, 8'd37, 8'd150, 8'd2, mode_t'(m));
            send_request(8'hAA, 8'h55, 8'h55, 8'hAA, mode_t'(m));
        end
    endtask

    // Empty windows on some channels, then a one-wide window on three of the four.
    task automatic test_empty_window;
        logic [7:0] lo [CHANNELS];
        logic [7:0] hi [CHANNELS];
        lo = '{8'd50, 8'd255, 8'd0, 8'd10};
        hi = '{8'd50, 8'd0, 8'd255, 8'd200};
        set_window(lo, hi);
        send_request(8'd60, 8'd128, 8'd255, 8'd180, MODE_MAGNITUDE);
        send_request(8'd60, 8'd128, 8'd0, 8'd180, MODE_DIFF);
        send_random(20);
        drain();
        lo = '{8'd0, 8'd0, 8'd254, 8'd127};
        hi = '{8'd1, 8'd255, 8'd255, 8'd128};
        set_window(lo, hi);
        send_random(40);
        drain();
    endtask

    // Random windows and requests under each idling pattern.
    task automatic test_random_phases;
        logic [7:0] lo [CHANNELS];
        logic [7:0] hi [CHANNELS];
        int idle_tab [4] = '{0, 75, 0, 35};
        int stall_tab [4] = '{0, 0, 75, 35};
        for (int p = 0; p < 8; p++) begin
            send_idle_pct = idle_tab[p % 4];
            recv_stall_pct = stall_tab[p % 4];
            for (int c = 0; c < CHANNELS; c++) begin
                lo[c] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(60));
                hi[c] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(255, 120));
            end
            set_window(lo, hi);
            send_random(130);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the receiver off so the pipeline fills and stalls its input.
    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(80);
        join
        drain();
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            cal_min[c] = MIN_RESET;
            cal_max[c] = MAX_RESET;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        drain();
        test_empty_window();
        test_random_phases();
        test_backpressure();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
